// File: src/pid_positional_incremental_assert.svh
// Assertion macros shared by the PID checker.
`ifndef PID_POSITIONAL_INCREMENTAL_ASSERT_SVH
`define PID_POSITIONAL_INCREMENTAL_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent; off during reset.
`define PIDPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent; off during reset.
`define PIDPI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check that also runs while reset is applied.
`define PIDPI_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pidpi_pkg.sv
// Types and constants shared by the PID controller modules.
`timescale 1ns / 1ps
`default_nettype none

package pidpi_pkg;

    // Register map, by word index
    typedef enum logic [2:0] {
        REG_MODE        = 3'd0,
        REG_GAIN_P      = 3'd1,
        REG_GAIN_I      = 3'd2,
        REG_GAIN_D      = 3'd3,
        REG_SUM_UPPER   = 3'd4,
        REG_SUM_LOWER   = 3'd5,
        REG_DRIVE_UPPER = 3'd6,
        REG_DRIVE_LOWER = 3'd7
    } reg_idx_t;

    localparam int unsigned FRAC_BITS = 8;
    localparam int unsigned ACC_W     = 42;
    localparam int unsigned RAW_W     = ACC_W - FRAC_BITS;

    // Configuration register file contents
    typedef struct packed {
        logic               mode_incremental;
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic signed [23:0] sum_upper;
        logic signed [23:0] sum_lower;
        logic signed [23:0] drive_upper;
        logic signed [23:0] drive_lower;
    } cfg_t;

    // Operands for the three gain products, already arranged for the mode
    typedef struct packed {
        logic signed [17:0] a;   // times gain_p
        logic signed [23:0] b;   // times gain_i
        logic signed [18:0] c;   // times gain_d
    } op_t;

endpackage

`default_nettype wire

// File: src/pid_positional_incremental.sv
// PID controller top level: register file, front end, queue and back end.
// Each beat on the s_ side carries a setpoint and a measurement and yields one
// beat on the m_ side with the clamped drive (positional form) or drive
// increment (incremental form) and a clamp flag. The block takes one beat per
// clock while the queue has room. The front end updates the error history and
// integral sum in the accepting clock, the back end runs a three-stage
// multiply, sum-and-scale and clamp pipeline, and a QUEUE_DEPTH-entry queue
// between them absorbs output stalls; s_tready drops only when that queue is
// full. Registers are written through the APB port at word addresses and
// should change only while no beat is in flight.
`timescale 1ns / 1ps
`default_nettype none

module pid_positional_incremental #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] setpoint, [31:16] measured
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // [23:0] drive
    output logic      [0:0]  m_tuser    // [0] clamped
);

    pidpi_pkg::cfg_t cfg_reg, cfg_next;
    pidpi_pkg::op_t  front_op, q_op;

    logic             wr_en;
    logic             accept;
    logic             q_full, q_valid, q_pop;
    logic signed [23:0] drive;
    logic             clamped;
    pidpi_pkg::reg_idx_t idx;

    assign pready = 1'b1;
    assign idx    = pidpi_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                pidpi_pkg::REG_MODE:        cfg_next.mode_incremental = pwdata[0];
                pidpi_pkg::REG_GAIN_P:      cfg_next.gain_p           = pwdata[15:0];
                pidpi_pkg::REG_GAIN_I:      cfg_next.gain_i           = pwdata[15:0];
                pidpi_pkg::REG_GAIN_D:      cfg_next.gain_d           = pwdata[15:0];
                pidpi_pkg::REG_SUM_UPPER:   cfg_next.sum_upper        = pwdata[23:0];
                pidpi_pkg::REG_SUM_LOWER:   cfg_next.sum_lower        = pwdata[23:0];
                pidpi_pkg::REG_DRIVE_UPPER: cfg_next.drive_upper      = pwdata[23:0];
                pidpi_pkg::REG_DRIVE_LOWER: cfg_next.drive_lower      = pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads, signed values sign-extended
    always_comb begin
        case (idx)
            pidpi_pkg::REG_MODE:        prdata = {31'd0, cfg_reg.mode_incremental};
            pidpi_pkg::REG_GAIN_P:      prdata = 32'(cfg_reg.gain_p);
            pidpi_pkg::REG_GAIN_I:      prdata = 32'(cfg_reg.gain_i);
            pidpi_pkg::REG_GAIN_D:      prdata = 32'(cfg_reg.gain_d);
            pidpi_pkg::REG_SUM_UPPER:   prdata = 32'(cfg_reg.sum_upper);
            pidpi_pkg::REG_SUM_LOWER:   prdata = 32'(cfg_reg.sum_lower);
            pidpi_pkg::REG_DRIVE_UPPER: prdata = 32'(cfg_reg.drive_upper);
            pidpi_pkg::REG_DRIVE_LOWER: prdata = 32'(cfg_reg.drive_lower);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode_incremental <= 1'b0;
            cfg_reg.gain_p           <= '0;
            cfg_reg.gain_i           <= '0;
            cfg_reg.gain_d           <= '0;
            cfg_reg.sum_upper        <= 24'sh7FFFFF;
            cfg_reg.sum_lower        <= 24'sh800000;
            cfg_reg.drive_upper      <= 24'sh7FFFFF;
            cfg_reg.drive_lower      <= 24'sh800000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept while the queue has room
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    pidpi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .accept   (accept),
        .setpoint (s_tdata[15:0]),
        .measured (s_tdata[31:16]),
        .op       (front_op)
    );

    pidpi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (front_op),
        .full      (q_full),
        .not_empty (q_valid),
        .pop       (q_pop),
        .pop_data  (q_op)
    );

    pidpi_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_op),
        .q_pop     (q_pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_drive   (drive),
        .m_clamped (clamped)
    );

    assign m_tdata = drive;
    assign m_tuser = clamped;

endmodule

`default_nettype wire

// File: src/pidpi_front.sv
// Front end: error, error history, integral sum and operand selection.
`timescale 1ns / 1ps
`default_nettype none

module pidpi_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire pidpi_pkg::cfg_t    cfg,
    input  wire logic               accept,
    input  wire logic signed [15:0] setpoint,
    input  wire logic signed [15:0] measured,
    output pidpi_pkg::op_t          op
);

    logic signed [16:0] last_error_reg, last_error_next;
    logic signed [16:0] older_error_reg, older_error_next;
    logic signed [23:0] error_sum_reg, error_sum_next;

    logic signed [16:0] err;
    logic signed [24:0] sum_raw;
    logic signed [24:0] sum_hi;
    logic signed [24:0] sum_lo;
    logic signed [24:0] sum_clip;
    logic signed [17:0] diff1;
    logic signed [18:0] diff2;

    // Form the error and its differences
    always_comb begin
        err   = {setpoint[15], setpoint} - {measured[15], measured};
        diff1 = {err[16], err} - {last_error_reg[16], last_error_reg};
        diff2 = {{2{err[16]}}, err} - {last_error_reg[16], last_error_reg, 1'b0}
              + {{2{older_error_reg[16]}}, older_error_reg};
    end

    // Accumulate and clamp the sum, lower limit applied last
    always_comb begin
        sum_raw  = {error_sum_reg[23], error_sum_reg} + {{8{err[16]}}, err};
        sum_hi   = {cfg.sum_upper[23], cfg.sum_upper};
        sum_lo   = {cfg.sum_lower[23], cfg.sum_lower};
        sum_clip = sum_raw;
        if (sum_clip > sum_hi) begin
            sum_clip = sum_hi;
        end
        if (sum_clip < sum_lo) begin
            sum_clip = sum_lo;
        end
    end

    // Pick operands by mode
    always_comb begin
        if (cfg.mode_incremental) begin
            op.a = diff1;
            op.b = {{7{err[16]}}, err};
            op.c = diff2;
        end else begin
            op.a = {err[16], err};
            op.b = sum_clip[23:0];
            op.c = {diff1[17], diff1};
        end
    end

    // Advance history on every accepted beat; hold the sum in incremental mode
    always_comb begin
        last_error_next  = last_error_reg;
        older_error_next = older_error_reg;
        error_sum_next   = error_sum_reg;
        if (accept) begin
            last_error_next  = err;
            older_error_next = last_error_reg;
            if (!cfg.mode_incremental) begin
                error_sum_next = sum_clip[23:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_error_reg  <= '0;
            older_error_reg <= '0;
            error_sum_reg   <= '0;
        end else begin
            last_error_reg  <= last_error_next;
            older_error_reg <= older_error_next;
            error_sum_reg   <= error_sum_next;
        end
    end

endmodule

`default_nettype wire

// File: src/pidpi_queue.sv
// Short operand queue between the front end and the multiply pipeline.
`timescale 1ns / 1ps
`default_nettype none

module pidpi_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire pidpi_pkg::op_t push_data,
    output logic                full,
    output logic                not_empty,
    input  wire logic           pop,
    output pidpi_pkg::op_t      pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pidpi_pkg::op_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    // Advance pointers with wrap and track fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: src/pidpi_back.sv
// Back end: gain products, sum and scale, drive clamp and output register.
`timescale 1ns / 1ps
`default_nettype none

module pidpi_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire pidpi_pkg::cfg_t cfg,
    input  wire logic            q_valid,
    input  wire pidpi_pkg::op_t  q_data,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic signed [23:0]   m_drive,
    output logic                 m_clamped
);

    localparam int unsigned ACC_W = pidpi_pkg::ACC_W;
    localparam int unsigned RAW_W = pidpi_pkg::RAW_W;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;

    logic signed [33:0]      prod_a_reg;
    logic signed [39:0]      prod_b_reg;
    logic signed [34:0]      prod_c_reg;
    logic signed [RAW_W-1:0] raw_reg;
    logic signed [23:0]      drive_reg;
    logic                    clamped_reg;

    logic out_ready, s2_ready, s1_ready;

    logic signed [17:0]      opa;
    logic signed [23:0]      opb;
    logic signed [18:0]      opc;
    logic signed [33:0]      prod_a;
    logic signed [39:0]      prod_b;
    logic signed [34:0]      prod_c;
    logic signed [ACC_W-1:0] acc;
    logic signed [RAW_W-1:0] lim_hi, lim_lo, drv;

    // Stall chain from the output back to the queue
    assign out_ready = !out_valid_reg || m_ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign q_pop     = q_valid && s1_ready;

    always_comb begin
        s1_valid_next  = s1_ready  ? q_valid      : s1_valid_reg;
        s2_valid_next  = s2_ready  ? s1_valid_reg : s2_valid_reg;
        out_valid_next = out_ready ? s2_valid_reg : out_valid_reg;
    end

    // Three gain products
    always_comb begin
        opa    = $signed(q_data.a);
        opb    = $signed(q_data.b);
        opc    = $signed(q_data.c);
        prod_a = cfg.gain_p * opa;
        prod_b = cfg.gain_i * opb;
        prod_c = cfg.gain_d * opc;
    end

    // Sum products and drop the fraction bits (floor)
    always_comb begin
        acc = ACC_W'(prod_a_reg) + ACC_W'(prod_b_reg) + ACC_W'(prod_c_reg);
    end

    // Clamp the drive, lower limit applied last
    always_comb begin
        lim_hi = RAW_W'(cfg.drive_upper);
        lim_lo = RAW_W'(cfg.drive_lower);
        drv    = raw_reg;
        if (drv > lim_hi) begin
            drv = lim_hi;
        end
        if (drv < lim_lo) begin
            drv = lim_lo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            prod_a_reg <= prod_a;
            prod_b_reg <= prod_b;
            prod_c_reg <= prod_c;
        end
        if (s2_ready) begin
            raw_reg <= acc[ACC_W-1:pidpi_pkg::FRAC_BITS];
        end
        if (out_ready) begin
            drive_reg   <= drv[23:0];
            clamped_reg <= (drv != raw_reg);
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_drive   = drive_reg;
    assign m_clamped = clamped_reg;

endmodule

`default_nettype wire

// File: src/pidpi_checker.sv
// Port-level checker for the PID controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "pid_positional_incremental_assert.svh"

module pidpi_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        psel,
    input wire logic [4:0]  paddr,
    input wire logic [31:0] prdata,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // Hold a stalled result beat
    `PIDPI_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat dropped or changed while stalled")

    // Input backpressure only comes from a stalled output
    `PIDPI_ASSERT_SAME(a_stall_src, aclk, aresetn, !s_tready, m_tvalid, "input stalled with no result pending")

    // Reset empties the pipeline
    `PIDPI_ASSERT_NEXT_ALWAYS(a_rst_empty, aclk, !aresetn, !m_tvalid && s_tready, "pipeline not empty after reset")

    // A mode read shows one bit only
    `PIDPI_ASSERT_SAME(a_mode_rd, aclk, aresetn, psel && paddr[4:2] == pidpi_pkg::REG_MODE, prdata[31:1] == 31'd0, "mode register read has stray bits")

endmodule

bind pid_positional_incremental pidpi_checker u_pidpi_checker (.*);

`default_nettype wire
